// ===== design/cfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsf_pkg - shared types and constants of the command frame / sample framer
// Request and response beat layouts, command and status codes, frame bytes.
// ----------------------------------------------------------------------------
package cfsf_pkg;

   // Field widths fixed by the interface
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SCALE_W  = 10;
   localparam int unsigned SHIFT_W  = 5;
   localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;
   localparam int unsigned INDEX_W  = 9;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SHIFT = 2'd1;

   // Register reset values
   localparam logic [SCALE_W-1:0] FULL_SCALE_RST  = 10'd330;
   localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RST = 5'd12;

   // Frame constants
   localparam logic [15:0] REQ_FLAG    = 16'hB10E;
   localparam logic [7:0]  ANS_FLAG_HI = 8'hB1;
   localparam logic [7:0]  ANS_FLAG_LO = 8'h0A;
   localparam logic [7:0]  ANS_LEN     = 8'h03;
   localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd511;

   // Beats of an outgoing sample frame
   localparam logic [2:0] BEAT_FLAG_HI = 3'd0;
   localparam logic [2:0] BEAT_FLAG_LO = 3'd1;
   localparam logic [2:0] BEAT_LEN     = 3'd2;
   localparam logic [2:0] BEAT_HI      = 3'd3;
   localparam logic [2:0] BEAT_LO      = 3'd4;
   localparam logic [2:0] BEAT_SUM     = 3'd5;

   typedef enum logic [1:0] {
      CMD_RX_BYTE    = 2'd0,
      CMD_TICK       = 2'd1,
      CMD_CONNECT    = 2'd2,
      CMD_DISCONNECT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NONE     = 3'd0,
      ST_START    = 3'd1,
      ST_STOP     = 3'd2,
      ST_OTHER    = 3'd3,
      ST_SHORT    = 3'd4,
      ST_BAD_FLAG = 3'd5,
      ST_BAD_SUM  = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [7:0]          rx_byte;
      logic                write_last;
      logic [SAMPLE_W-1:0] adc_sample;
   } req_item_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       last;
      logic [2:0] frame_status;
      logic       collecting;
      logic       connected;
   } rsp_item_type;

   // Work handed from the front part to the back part
   typedef struct packed {
      logic              is_frame;
      logic [2:0]        status;
      logic              collecting;
      logic              connected;
      logic [PROD_W-1:0] product;
   } job_type;

endpackage

// ===== design/command_frame_and_sample_framer_unit.sv =====
// ----------------------------------------------------------------------------
// command_frame_and_sample_framer_unit - command parser and sample framer
// Top level: configuration registers, parser, job queue and frame emitter.
// ----------------------------------------------------------------------------
// One request beat is taken every cycle while req_full is low. Received bytes,
// link events and idle ticks each give one response beat; a tick while the
// link is up and collection is on gives six beats (B1 0A 03 HI LO SUM), which
// the back part emits at one per cycle while the response side keeps popping,
// so the sustained request rate is one per cycle for plain beats and lower for
// emitting ticks. A beat reaches the response side through the job queue, which
// captures it when its request is taken, and the output register, which takes
// it when the back part loads the job; a four-entry job queue lets the parser
// run ahead of the emitter. The configuration channel is always ready.
module command_frame_and_sample_framer_unit #(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  cfsf_pkg::req_item_type            req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output cfsf_pkg::rsp_item_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cfsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfsf_pkg::SCALE_W-1:0]      csr_wdata
);
   import cfsf_pkg::*;

   logic [SCALE_W-1:0] full_scale_ff;
   logic [SHIFT_W-1:0] scale_shift_ff;
   logic               accept;
   job_type            front_job;
   job_type            back_job;
   logic               job_empty;
   logic               job_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff  <= FULL_SCALE_RST;
         scale_shift_ff <= SCALE_SHIFT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FULL_SCALE) begin
            full_scale_ff <= csr_wdata;
         end else if (csr_index == CSR_SCALE_SHIFT) begin
            scale_shift_ff <= csr_wdata[SHIFT_W-1:0];
         end
      end
   end

   cfsf_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .full_scale (full_scale_ff),
      .job        (front_job)
   );

   cfsf_queue #(
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_job),
      .full      (req_full),
      .pop       (job_pop),
      .pop_data  (back_job),
      .empty     (job_empty)
   );

   cfsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (back_job),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .scale_shift (scale_shift_ff),
      .rsp_data    (rsp_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop)
   );

endmodule

// ===== design/cfsf_front.sv =====
// ----------------------------------------------------------------------------
// cfsf_front - request parser
// Parses received writes, tracks link and collection state and turns every
// request beat into one job for the back part; ticks get their product here.
// ----------------------------------------------------------------------------
module cfsf_front #(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  cfsf_pkg::req_item_type         req,
   input  logic [cfsf_pkg::SCALE_W-1:0]   full_scale,
   output cfsf_pkg::job_type              job
);
   import cfsf_pkg::*;

   localparam int unsigned KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W:0] SAMPLE_MASK_W = (SAMPLE_W + 1)'((1 << KEEP_BITS) - 1);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_MASK_W[SAMPLE_W-1:0];

   logic               link_ff, link_in;
   logic               collect_ff, collect_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [7:0]         flag_hi_ff, flag_hi_in;
   logic [7:0]         flag_lo_ff, flag_lo_in;
   logic [7:0]         length_ff, length_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         first_ff, first_in;
   logic               decided_ff, decided_in;

   logic [7:0]          sum_add;
   logic                finish;
   status_type          status;
   logic [SAMPLE_W-1:0] sample;

   assign sum_add = sum_ff + req.rx_byte;
   assign sample  = req.adc_sample & SAMPLE_MASK;

   // Parser and link state update for one request beat
   always_comb begin
      link_in    = link_ff;
      collect_in = collect_ff;
      index_in   = index_ff;
      flag_hi_in = flag_hi_ff;
      flag_lo_in = flag_lo_ff;
      length_in  = length_ff;
      sum_in     = sum_ff;
      first_in   = first_ff;
      decided_in = decided_ff;
      finish     = 1'b0;
      status     = ST_NONE;
      unique case (cmd_type'(req.command))
         CMD_RX_BYTE: begin
            if (!decided_ff) begin
               if (index_ff == INDEX_W'(0)) begin
                  flag_hi_in = req.rx_byte;
                  sum_in     = req.rx_byte;
               end else if (index_ff == INDEX_W'(1)) begin
                  flag_lo_in = req.rx_byte;
                  sum_in     = sum_add;
               end else if (index_ff == INDEX_W'(2)) begin
                  length_in = req.rx_byte;
                  if (req.rx_byte == 8'd0) begin
                     finish = 1'b1;
                  end else begin
                     sum_in = sum_add;
                  end
               end else begin
                  if (index_ff == INDEX_W'(3)) begin
                     first_in = req.rx_byte;
                  end
                  if (index_ff == INDEX_W'(2) + INDEX_W'(length_ff)) begin
                     finish = 1'b1;
                  end else begin
                     sum_in = sum_add;
                  end
               end
            end
            // frame complete by length: judge it
            if (finish) begin
               decided_in = 1'b1;
               if ({flag_hi_in, flag_lo_in} != REQ_FLAG) begin
                  status = ST_BAD_FLAG;
               end else if (length_in == 8'd0 || sum_ff != req.rx_byte) begin
                  status = ST_BAD_SUM;
               end else if (first_in == 8'd0) begin
                  status     = ST_START;
                  collect_in = 1'b1;
               end else if (first_in == 8'd1) begin
                  status     = ST_STOP;
                  collect_in = 1'b0;
               end else begin
                  status = ST_OTHER;
               end
            end
            if (!decided_in && index_ff < INDEX_MAX) begin
               index_in = index_ff + INDEX_W'(1);
            end
            // end of write: report short frame, clear parser
            if (req.write_last) begin
               if (!decided_in && status == ST_NONE) begin
                  status = ST_SHORT;
               end
               index_in   = '0;
               flag_hi_in = '0;
               flag_lo_in = '0;
               length_in  = '0;
               sum_in     = '0;
               first_in   = '0;
               decided_in = 1'b0;
            end
         end
         CMD_TICK: begin
         end
         CMD_CONNECT: begin
            link_in = 1'b1;
         end
         CMD_DISCONNECT: begin
            link_in    = 1'b0;
            collect_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Job for the back part
   always_comb begin
      job.is_frame   = (cmd_type'(req.command) == CMD_TICK) && link_ff && collect_ff;
      job.status     = status;
      job.collecting = collect_in;
      job.connected  = link_in;
      job.product    = PROD_W'(sample) * PROD_W'(full_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff    <= 1'b0;
         collect_ff <= 1'b0;
         index_ff   <= '0;
         flag_hi_ff <= '0;
         flag_lo_ff <= '0;
         length_ff  <= '0;
         sum_ff     <= '0;
         first_ff   <= '0;
         decided_ff <= 1'b0;
      end else if (accept) begin
         link_ff    <= link_in;
         collect_ff <= collect_in;
         index_ff   <= index_in;
         flag_hi_ff <= flag_hi_in;
         flag_lo_ff <= flag_lo_in;
         length_ff  <= length_in;
         sum_ff     <= sum_in;
         first_ff   <= first_in;
         decided_ff <= decided_in;
      end
   end

`ifndef ASSERT_OFF
   // a decided frame has its byte count frozen until the write ends
   a_decided_holds_index: assert property (@(posedge clock) disable iff (reset)
      (accept && decided_ff && !req.write_last) |=> $stable(index_ff))
      else $error("byte index moved after frame decision");

   // status is only ever reported for received bytes
   a_status_on_bytes: assert property (@(posedge clock) disable iff (reset)
      (accept && job.status != ST_NONE) |-> (cmd_type'(req.command) == CMD_RX_BYTE))
      else $error("frame status on a non-byte request");

   // collection can only be turned on by a good start frame
   a_collect_rise: assert property (@(posedge clock) disable iff (reset)
      (accept && !collect_ff && collect_in) |-> (status == ST_START))
      else $error("collection enabled without start frame");
`endif

endmodule

// ===== design/cfsf_queue.sv =====
// ----------------------------------------------------------------------------
// cfsf_queue - short job queue
// Decouples the parser from the frame emitter so each side stalls on its own.
// ----------------------------------------------------------------------------
module cfsf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cfsf_pkg::job_type   push_data,
   output logic                full,
   input  logic                pop,
   output cfsf_pkg::job_type   pop_data,
   output logic                empty
);
   import cfsf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_FULL) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/cfsf_back.sv =====
// ----------------------------------------------------------------------------
// cfsf_back - response emitter
// Takes jobs from the queue, emits one response beat for plain jobs and six
// beats for a sample frame, through a single output register.
// ----------------------------------------------------------------------------
module cfsf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cfsf_pkg::job_type             job,
   input  logic                          job_empty,
   output logic                          job_pop,
   input  logic [cfsf_pkg::SHIFT_W-1:0]  scale_shift,
   output cfsf_pkg::rsp_item_type        rsp_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop
);
   import cfsf_pkg::*;

   logic [2:0]        beat_ff, beat_in;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_ff, out_in;
   logic              load;
   logic [PROD_W-1:0] shifted;
   logic [15:0]       value;
   logic [7:0]        sum;
   logic [7:0]        frame_byte;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign load      = !job_empty && (!out_valid_ff || rsp_pop);

   // scaled value with saturation and frame checksum
   assign shifted = job.product >> scale_shift;
   assign value   = (|shifted[PROD_W-1:16]) ? 16'hFFFF : shifted[15:0];
   assign sum     = ANS_FLAG_HI + ANS_FLAG_LO + ANS_LEN + value[15:8] + value[7:0];

   always_comb begin
      unique case (beat_ff)
         BEAT_FLAG_HI: frame_byte = ANS_FLAG_HI;
         BEAT_FLAG_LO: frame_byte = ANS_FLAG_LO;
         BEAT_LEN:     frame_byte = ANS_LEN;
         BEAT_HI:      frame_byte = value[15:8];
         BEAT_LO:      frame_byte = value[7:0];
         BEAT_SUM:     frame_byte = sum;
         default:      frame_byte = 8'd0;
      endcase
   end

   // next output beat
   always_comb begin
      beat_in      = beat_ff;
      out_in       = out_ff;
      job_pop      = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load) begin
         out_valid_in       = 1'b1;
         out_in.collecting  = job.collecting;
         out_in.connected   = job.connected;
         if (job.is_frame) begin
            out_in.tx_valid     = 1'b1;
            out_in.tx_byte      = frame_byte;
            out_in.last         = (beat_ff == BEAT_SUM);
            out_in.frame_status = ST_NONE;
            job_pop             = (beat_ff == BEAT_SUM);
            beat_in             = (beat_ff == BEAT_SUM) ? BEAT_FLAG_HI : beat_ff + 3'd1;
         end else begin
            out_in.tx_valid     = 1'b0;
            out_in.tx_byte      = 8'd0;
            out_in.last         = 1'b1;
            out_in.frame_status = job.status;
            job_pop             = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= BEAT_FLAG_HI;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

`ifndef ASSERT_OFF
   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      beat_ff <= BEAT_SUM)
      else $error("frame beat counter out of range");

   a_idle_beat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.tx_valid) |-> (out_ff.tx_byte == 8'd0 && out_ff.last))
      else $error("non-frame beat carries a byte or is not last");

   a_frame_no_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.tx_valid) |-> (out_ff.frame_status == ST_NONE))
      else $error("frame beat carries a status");

   a_mid_frame_job_held: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != BEAT_FLAG_HI) |-> !job_empty)
      else $error("sample frame job lost mid-frame");
`endif

endmodule
